FILE: rtl/core/plane_angle_from_normals_assert.svh
// Assertion macros for the plane angle block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef PLANE_ANGLE_FROM_NORMALS_ASSERT_SVH
`define PLANE_ANGLE_FROM_NORMALS_ASSERT_SVH

// Same-cycle implication.
`define PAFN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plane angle check failed");

// Next-cycle implication.
`define PAFN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plane angle check failed");

`endif

FILE: rtl/core/pafn_pkg.sv
// ----------------------------------------------------------------------------
// pafn_pkg
// Widths, constants and shared types of the plane angle pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pafn_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int ANGLE_FRAC_BITS = 15;
    localparam int ANGLE_W         = ANGLE_FRAC_BITS + 1;

    // cosine and sine fraction bits, CORDIC depth
    localparam int QBITS        = 30;
    localparam int CORDIC_STEPS = 30;

    localparam int PROD_W    = 2 * COORD_WIDTH;
    localparam int NORM_W    = 2 * COORD_WIDTH;
    localparam int DOT_W     = 2 * COORD_WIDTH + 2;
    localparam int DEN_W     = 2 * NORM_W;
    localparam int QUO_W     = 2 * QBITS + 1;
    localparam int DIV_STEPS = 2 * QBITS;
    localparam int ROOT_W    = QBITS + 1;
    localparam int DL_W      = QUO_W + 2;
    localparam int CX_W      = QBITS + 4;
    localparam int Z_W       = QBITS + 2;

    localparam logic [Z_W-1:0] HALF_PI    = Z_W'(1686629713);
    localparam int             RND_SHIFT  = QBITS - ANGLE_FRAC_BITS;
    localparam logic [Z_W-1:0] RND_HALF   = Z_W'(1) << (RND_SHIFT - 1);
    localparam logic [Z_W-1:0] ANGLE_MAXZ = (HALF_PI + RND_HALF) >> RND_SHIFT;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_MAXZ[ANGLE_W-1:0];

    // atan(2^-i) in Q30, rounded to nearest
    localparam logic [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        Z_W'(843314857), Z_W'(497837829), Z_W'(263043837), Z_W'(133525159),
        Z_W'(67021687),  Z_W'(33543516),  Z_W'(16775851),  Z_W'(8388437),
        Z_W'(4194283),   Z_W'(2097149),   Z_W'(1048576),   Z_W'(524288),
        Z_W'(262144),    Z_W'(131072),    Z_W'(65536),     Z_W'(32768),
        Z_W'(16384),     Z_W'(8192),      Z_W'(4096),      Z_W'(2048),
        Z_W'(1024),      Z_W'(512),       Z_W'(256),       Z_W'(128),
        Z_W'(64),        Z_W'(32),        Z_W'(16),        Z_W'(8),
        Z_W'(4),         Z_W'(2)
    };

    // control that travels with each word down the pipe
    typedef struct packed {
        logic valid;
        logic zero;
    } tag_t;

endpackage

`default_nettype wire

FILE: rtl/core/pafn_front.sv
// ----------------------------------------------------------------------------
// pafn_front
// Squared norms, absolute dot product and the wide products D^2, S1*S2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pafn_front
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  adv,
    input  wire logic                                  in_valid,
    input  wire logic signed [pafn_pkg::COORD_WIDTH-1:0] first_x,
    input  wire logic signed [pafn_pkg::COORD_WIDTH-1:0] first_y,
    input  wire logic signed [pafn_pkg::COORD_WIDTH-1:0] first_z,
    input  wire logic signed [pafn_pkg::COORD_WIDTH-1:0] second_x,
    input  wire logic signed [pafn_pkg::COORD_WIDTH-1:0] second_y,
    input  wire logic signed [pafn_pkg::COORD_WIDTH-1:0] second_z,
    output pafn_pkg::tag_t                             out_tag,
    output logic [pafn_pkg::DEN_W-1:0]                 dd,
    output logic [pafn_pkg::DEN_W-1:0]                 den
);

    logic signed [pafn_pkg::COORD_WIDTH-1:0] a [3];
    logic signed [pafn_pkg::COORD_WIDTH-1:0] b [3];

    logic signed [pafn_pkg::PROD_W-1:0] sq1_next [3];
    logic signed [pafn_pkg::PROD_W-1:0] sq2_next [3];
    logic signed [pafn_pkg::PROD_W-1:0] cr_next  [3];
    logic signed [pafn_pkg::PROD_W-1:0] sq1_reg  [3];
    logic signed [pafn_pkg::PROD_W-1:0] sq2_reg  [3];
    logic signed [pafn_pkg::PROD_W-1:0] cr_reg   [3];
    logic                               v1_reg;

    logic signed [pafn_pkg::DOT_W-1:0]  dot_sum;
    logic [pafn_pkg::NORM_W-1:0]        s1_next;
    logic [pafn_pkg::NORM_W-1:0]        s2_next;
    logic [pafn_pkg::NORM_W-1:0]        dot_next;
    logic [pafn_pkg::NORM_W-1:0]        s1_reg;
    logic [pafn_pkg::NORM_W-1:0]        s2_reg;
    logic [pafn_pkg::NORM_W-1:0]        dot_reg;
    pafn_pkg::tag_t                     t2_next;
    pafn_pkg::tag_t                     t2_reg;

    logic [pafn_pkg::DEN_W-1:0]         dd_next;
    logic [pafn_pkg::DEN_W-1:0]         den_next;
    logic [pafn_pkg::DEN_W-1:0]         dd_reg;
    logic [pafn_pkg::DEN_W-1:0]         den_reg;
    pafn_pkg::tag_t                     t3_reg;

    assign a[0] = first_x;
    assign a[1] = first_y;
    assign a[2] = first_z;
    assign b[0] = second_x;
    assign b[1] = second_y;
    assign b[2] = second_z;

    // stage 1: squares and per-axis products a*b
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq1_next[i] = pafn_pkg::PROD_W'(a[i]) * pafn_pkg::PROD_W'(a[i]);
            sq2_next[i] = pafn_pkg::PROD_W'(b[i]) * pafn_pkg::PROD_W'(b[i]);
            cr_next[i]  = pafn_pkg::PROD_W'(a[i]) * pafn_pkg::PROD_W'(b[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            t2_reg <= '0;
            t3_reg <= '0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            t2_reg <= t2_next;
            t3_reg <= t2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq1_reg <= sq1_next;
            sq2_reg <= sq2_next;
            cr_reg  <= cr_next;
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            dot_reg <= dot_next;
            dd_reg  <= dd_next;
            den_reg <= den_next;
        end
    end

    // stage 2: sums, magnitude of the dot product, zero-length check
    always_comb
    begin
        s1_next = $unsigned(sq1_reg[0]) + $unsigned(sq1_reg[1]) + $unsigned(sq1_reg[2]);
        s2_next = $unsigned(sq2_reg[0]) + $unsigned(sq2_reg[1]) + $unsigned(sq2_reg[2]);
        dot_sum = pafn_pkg::DOT_W'(cr_reg[0]) + pafn_pkg::DOT_W'(cr_reg[1])
                + pafn_pkg::DOT_W'(cr_reg[2]);
        dot_next = dot_sum[pafn_pkg::DOT_W-1] ? pafn_pkg::NORM_W'(-dot_sum)
                                              : pafn_pkg::NORM_W'(dot_sum);
        t2_next.valid = v1_reg;
        t2_next.zero  = (s1_next == '0) || (s2_next == '0);
    end

    // stage 3: wide products
    always_comb
    begin
        dd_next  = pafn_pkg::DEN_W'(dot_reg) * pafn_pkg::DEN_W'(dot_reg);
        den_next = pafn_pkg::DEN_W'(s1_reg) * pafn_pkg::DEN_W'(s2_reg);
    end

    assign out_tag = t3_reg;
    assign dd      = dd_reg;
    assign den     = den_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pafn_divide.sv
// ----------------------------------------------------------------------------
// pafn_divide
// Restoring divider, one quotient bit per stage: Qc = floor(D^2 * 2^60 / den).
// The sine square Qs follows from the remainder since D^2 + rest = den.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pafn_divide
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire pafn_pkg::tag_t                in_tag,
    input  wire logic [pafn_pkg::DEN_W-1:0]    dd,
    input  wire logic [pafn_pkg::DEN_W-1:0]    den,
    output pafn_pkg::tag_t                     out_tag,
    output logic [pafn_pkg::QUO_W-1:0]         qc,
    output logic [pafn_pkg::QUO_W-1:0]         qs
);

    pafn_pkg::tag_t               tag_reg [pafn_pkg::DIV_STEPS+1];
    logic [pafn_pkg::DEN_W-1:0]   rem_reg [pafn_pkg::DIV_STEPS+1];
    logic [pafn_pkg::DEN_W-1:0]   den_reg [pafn_pkg::DIV_STEPS+1];
    logic [pafn_pkg::QUO_W-1:0]   quo_reg [pafn_pkg::DIV_STEPS+1];

    pafn_pkg::tag_t               otag_reg;
    logic [pafn_pkg::QUO_W-1:0]   qc_reg;
    logic [pafn_pkg::QUO_W-1:0]   qs_reg;
    logic [pafn_pkg::QUO_W-1:0]   qs_next;

    genvar k;
    generate
        for (k = 0; k <= pafn_pkg::DIV_STEPS; k++)
        begin : g_step
            logic                         ge;
            logic [pafn_pkg::DEN_W:0]     rem2;
            logic [pafn_pkg::DEN_W:0]     den2;
            logic [pafn_pkg::DEN_W-1:0]   rem_next;
            logic [pafn_pkg::QUO_W-1:0]   quo_next;
            pafn_pkg::tag_t               tag_in;
            logic [pafn_pkg::DEN_W-1:0]   den_in;

            if (k == 0)
            begin : g_first
                // leading compare: quotient bit 60 is set only when D^2 == den
                always_comb
                begin
                    tag_in   = in_tag;
                    den_in   = den;
                    rem2     = {1'b0, dd};
                    den2     = {1'b0, den};
                    ge       = rem2 >= den2;
                    rem_next = ge ? pafn_pkg::DEN_W'(rem2 - den2) : dd;
                    quo_next = '0;
                    quo_next[pafn_pkg::DIV_STEPS] = ge;
                end
            end
            else
            begin : g_next
                // shift in a zero, trial subtract
                always_comb
                begin
                    tag_in   = tag_reg[k-1];
                    den_in   = den_reg[k-1];
                    rem2     = {rem_reg[k-1], 1'b0};
                    den2     = {1'b0, den_reg[k-1]};
                    ge       = rem2 >= den2;
                    rem_next = ge ? pafn_pkg::DEN_W'(rem2 - den2)
                                  : pafn_pkg::DEN_W'(rem2);
                    quo_next = quo_reg[k-1];
                    quo_next[pafn_pkg::DIV_STEPS-k] = ge;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tag_reg[k] <= '0;
                end
                else if (adv)
                begin
                    tag_reg[k] <= tag_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                    quo_reg[k] <= quo_next;
                end
            end
        end
    endgenerate

    // sine square: 2^60 - Qc, less one more when the division was inexact
    always_comb
    begin
        qs_next = (pafn_pkg::QUO_W'(1) << pafn_pkg::DIV_STEPS)
                - quo_reg[pafn_pkg::DIV_STEPS]
                - pafn_pkg::QUO_W'(rem_reg[pafn_pkg::DIV_STEPS] != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            otag_reg <= '0;
        end
        else if (adv)
        begin
            otag_reg <= tag_reg[pafn_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qc_reg <= quo_reg[pafn_pkg::DIV_STEPS];
            qs_reg <= qs_next;
        end
    end

    assign out_tag = otag_reg;
    assign qc      = qc_reg;
    assign qs      = qs_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pafn_root.sv
// ----------------------------------------------------------------------------
// pafn_root
// Two-lane bitwise integer square root, one result bit per stage.
// Lane 0 gives the Q30 cosine, lane 1 the Q30 sine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pafn_root
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire pafn_pkg::tag_t                in_tag,
    input  wire logic [pafn_pkg::QUO_W-1:0]    qc,
    input  wire logic [pafn_pkg::QUO_W-1:0]    qs,
    output pafn_pkg::tag_t                     out_tag,
    output logic [pafn_pkg::ROOT_W-1:0]        root_c,
    output logic [pafn_pkg::ROOT_W-1:0]        root_s
);

    pafn_pkg::tag_t               tag_reg [pafn_pkg::QBITS+1];
    logic [pafn_pkg::QUO_W-1:0]   rem_reg [2][pafn_pkg::QBITS+1];
    logic [pafn_pkg::ROOT_W-1:0]  rt_reg  [2][pafn_pkg::QBITS+1];

    genvar j, l;
    generate
        for (j = 0; j <= pafn_pkg::QBITS; j++)
        begin : g_stage
            pafn_pkg::tag_t tag_in;

            if (j == 0)
            begin : g_tin0
                assign tag_in = in_tag;
            end
            else
            begin : g_tinn
                assign tag_in = tag_reg[j-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tag_reg[j] <= '0;
                end
                else if (adv)
                begin
                    tag_reg[j] <= tag_in;
                end
            end

            for (l = 0; l < 2; l++)
            begin : g_lane
                logic [pafn_pkg::QUO_W-1:0]  rem_in;
                logic [pafn_pkg::ROOT_W-1:0] rt_in;
                logic [pafn_pkg::DL_W-1:0]   delta;
                logic [pafn_pkg::DL_W-1:0]   rem_ext;
                logic                        fit;
                logic [pafn_pkg::QUO_W-1:0]  rem_next;
                logic [pafn_pkg::ROOT_W-1:0] rt_next;

                if (j == 0)
                begin : g_in0
                    assign rem_in = (l == 0) ? qc : qs;
                    assign rt_in  = '0;
                end
                else
                begin : g_inn
                    assign rem_in = rem_reg[l][j-1];
                    assign rt_in  = rt_reg[l][j-1];
                end

                // try bit b: (t + 2^b)^2 - t^2 = t*2^(b+1) + 2^(2b)
                always_comb
                begin
                    delta = (pafn_pkg::DL_W'(rt_in) << (pafn_pkg::QBITS - j + 1))
                          + (pafn_pkg::DL_W'(1) << (2 * (pafn_pkg::QBITS - j)));
                    rem_ext  = pafn_pkg::DL_W'(rem_in);
                    fit      = delta <= rem_ext;
                    rem_next = fit ? pafn_pkg::QUO_W'(rem_ext - delta) : rem_in;
                    rt_next  = rt_in;
                    rt_next[pafn_pkg::QBITS-j] = fit;
                end

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        rem_reg[l][j] <= rem_next;
                        rt_reg[l][j]  <= rt_next;
                    end
                end
            end
        end
    endgenerate

    assign out_tag = tag_reg[pafn_pkg::QBITS];
    assign root_c  = rt_reg[0][pafn_pkg::QBITS];
    assign root_s  = rt_reg[1][pafn_pkg::QBITS];

endmodule

`default_nettype wire

FILE: rtl/core/pafn_cordic.sv
// ----------------------------------------------------------------------------
// pafn_cordic
// Vectoring CORDIC, one rotation per stage, then clamp, round and the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pafn_cordic
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              adv,
    input  wire pafn_pkg::tag_t                    in_tag,
    input  wire logic [pafn_pkg::ROOT_W-1:0]       cos_q,
    input  wire logic [pafn_pkg::ROOT_W-1:0]       sin_q,
    output logic                                   out_valid,
    output logic [pafn_pkg::ANGLE_W-1:0]           angle,
    output logic                                   zero
);

    localparam int N = pafn_pkg::CORDIC_STEPS;

    pafn_pkg::tag_t                      tag_reg [N];
    logic signed [pafn_pkg::CX_W-1:0]    x_reg   [N];
    logic signed [pafn_pkg::CX_W-1:0]    y_reg   [N];
    logic signed [pafn_pkg::Z_W-1:0]     z_reg   [N];

    logic signed [pafn_pkg::Z_W-1:0]     z_last;
    logic [pafn_pkg::Z_W-1:0]            z_clamp;
    logic [pafn_pkg::Z_W-1:0]            z_round;
    logic [pafn_pkg::ANGLE_W-1:0]        angle_next;
    logic                                valid_reg;
    logic                                zero_reg;
    logic [pafn_pkg::ANGLE_W-1:0]        angle_reg;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_rot
            pafn_pkg::tag_t                    tag_in;
            logic signed [pafn_pkg::CX_W-1:0]  x_in;
            logic signed [pafn_pkg::CX_W-1:0]  y_in;
            logic signed [pafn_pkg::Z_W-1:0]   z_in;
            logic signed [pafn_pkg::CX_W-1:0]  dx;
            logic signed [pafn_pkg::CX_W-1:0]  dy;
            logic signed [pafn_pkg::CX_W-1:0]  x_next;
            logic signed [pafn_pkg::CX_W-1:0]  y_next;
            logic signed [pafn_pkg::Z_W-1:0]   z_next;

            if (i == 0)
            begin : g_in0
                assign tag_in = in_tag;
                assign x_in   = signed'(pafn_pkg::CX_W'(cos_q));
                assign y_in   = signed'(pafn_pkg::CX_W'(sin_q));
                assign z_in   = '0;
            end
            else
            begin : g_inn
                assign tag_in = tag_reg[i-1];
                assign x_in   = x_reg[i-1];
                assign y_in   = y_reg[i-1];
                assign z_in   = z_reg[i-1];
            end

            // rotate toward the x axis, accumulate the angle
            always_comb
            begin
                dx = y_in >>> i;
                dy = x_in >>> i;
                if (!y_in[pafn_pkg::CX_W-1])
                begin
                    x_next = x_in + dx;
                    y_next = y_in - dy;
                    z_next = z_in + signed'(pafn_pkg::ATAN_TAB[i]);
                end
                else
                begin
                    x_next = x_in - dx;
                    y_next = y_in + dy;
                    z_next = z_in - signed'(pafn_pkg::ATAN_TAB[i]);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tag_reg[i] <= '0;
                end
                else if (adv)
                begin
                    tag_reg[i] <= tag_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    x_reg[i] <= x_next;
                    y_reg[i] <= y_next;
                    z_reg[i] <= z_next;
                end
            end
        end
    endgenerate

    // clamp to [0, pi/2], round half up, force zero on a zero-length normal
    always_comb
    begin
        z_last = z_reg[N-1];
        if (z_last[pafn_pkg::Z_W-1])
        begin
            z_clamp = '0;
        end
        else if ($unsigned(z_last) > pafn_pkg::HALF_PI)
        begin
            z_clamp = pafn_pkg::HALF_PI;
        end
        else
        begin
            z_clamp = $unsigned(z_last);
        end
        z_round    = (z_clamp + pafn_pkg::RND_HALF) >> pafn_pkg::RND_SHIFT;
        angle_next = tag_reg[N-1].zero ? '0 : z_round[pafn_pkg::ANGLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= tag_reg[N-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            angle_reg <= angle_next;
            zero_reg  <= tag_reg[N-1].zero;
        end
    end

    assign out_valid = valid_reg;
    assign angle     = angle_reg;
    assign zero      = zero_reg;

endmodule

`default_nettype wire

FILE: rtl/core/plane_angle_from_normals.sv
// ----------------------------------------------------------------------------
// plane_angle_from_normals
// Acute angle between two planes from their normal vectors, in Q15 radians.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_stall  | first_x/y/z, second_x/y/z (signed)
//   out     | out_valid/out_stall| angle_rad, zero_normal
//
// One word per cycle enters while in_stall is low. Each word passes through
// the norms and wide products, the one-bit-per-stage divider, the square
// roots and the 30 CORDIC rotations plus the output register, in that order.
// Reset clears every valid bit; payload registers are not reset.
// The whole pipe holds while a finished word waits under out_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plane_angle_from_normals
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire logic signed [pafn_pkg::COORD_WIDTH-1:0] first_x,
    input  wire logic signed [pafn_pkg::COORD_WIDTH-1:0] first_y,
    input  wire logic signed [pafn_pkg::COORD_WIDTH-1:0] first_z,
    input  wire logic signed [pafn_pkg::COORD_WIDTH-1:0] second_x,
    input  wire logic signed [pafn_pkg::COORD_WIDTH-1:0] second_y,
    input  wire logic signed [pafn_pkg::COORD_WIDTH-1:0] second_z,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic [pafn_pkg::ANGLE_W-1:0]                 angle_rad,
    output logic                                         zero_normal
);

    logic                         adv;
    pafn_pkg::tag_t               fr_tag;
    logic [pafn_pkg::DEN_W-1:0]   fr_dd;
    logic [pafn_pkg::DEN_W-1:0]   fr_den;
    pafn_pkg::tag_t               dv_tag;
    logic [pafn_pkg::QUO_W-1:0]   dv_qc;
    logic [pafn_pkg::QUO_W-1:0]   dv_qs;
    pafn_pkg::tag_t               rt_tag;
    logic [pafn_pkg::ROOT_W-1:0]  rt_cos;
    logic [pafn_pkg::ROOT_W-1:0]  rt_sin;

    // advance everything unless the output word is held
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    pafn_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .first_x  (first_x),
        .first_y  (first_y),
        .first_z  (first_z),
        .second_x (second_x),
        .second_y (second_y),
        .second_z (second_z),
        .out_tag  (fr_tag),
        .dd       (fr_dd),
        .den      (fr_den)
    );

    pafn_divide u_divide
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_tag  (fr_tag),
        .dd      (fr_dd),
        .den     (fr_den),
        .out_tag (dv_tag),
        .qc      (dv_qc),
        .qs      (dv_qs)
    );

    pafn_root u_root
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_tag  (dv_tag),
        .qc      (dv_qc),
        .qs      (dv_qs),
        .out_tag (rt_tag),
        .root_c  (rt_cos),
        .root_s  (rt_sin)
    );

    pafn_cordic u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_tag    (rt_tag),
        .cos_q     (rt_cos),
        .sin_q     (rt_sin),
        .out_valid (out_valid),
        .angle     (angle_rad),
        .zero      (zero_normal)
    );

endmodule

`default_nettype wire

FILE: rtl/core/plane_angle_from_normals_chk.sv
// ----------------------------------------------------------------------------
// plane_angle_from_normals_chk
// Port-level checks of the plane angle block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "plane_angle_from_normals_assert.svh"

module plane_angle_from_normals_chk
(
    input wire logic                                    clk,
    input wire logic                                    rst_n,
    input wire logic                                    in_valid,
    input wire logic                                    in_stall,
    input wire logic signed [pafn_pkg::COORD_WIDTH-1:0] first_x,
    input wire logic signed [pafn_pkg::COORD_WIDTH-1:0] first_y,
    input wire logic signed [pafn_pkg::COORD_WIDTH-1:0] first_z,
    input wire logic signed [pafn_pkg::COORD_WIDTH-1:0] second_x,
    input wire logic signed [pafn_pkg::COORD_WIDTH-1:0] second_y,
    input wire logic signed [pafn_pkg::COORD_WIDTH-1:0] second_z,
    input wire logic                                    out_valid,
    input wire logic                                    out_stall,
    input wire logic [pafn_pkg::ANGLE_W-1:0]            angle_rad,
    input wire logic                                    zero_normal
);

    logic [pafn_pkg::COORD_WIDTH-1:0] in_xor;

    // fold the input word so every port is observed
    assign in_xor = first_x ^ first_y ^ first_z ^ second_x ^ second_y ^ second_z
                  ^ {pafn_pkg::COORD_WIDTH{in_valid}};

    // a held output word stays
    `PAFN_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)
    `PAFN_ASSERT_NEXT(a_hold_word, out_valid && out_stall && !$isunknown(in_xor), $stable(angle_rad) && $stable(zero_normal))

    // a zero-length normal gives a zero angle
    `PAFN_ASSERT_NOW(a_zero_angle, out_valid && zero_normal, angle_rad == '0)

    // the angle never passes pi/2
    `PAFN_ASSERT_NOW(a_angle_range, out_valid, angle_rad <= pafn_pkg::ANGLE_MAX)

    // the input side flows whenever the output is not held
    `PAFN_ASSERT_NOW(a_in_flow, !(out_valid && out_stall), !in_stall)

endmodule

bind plane_angle_from_normals plane_angle_from_normals_chk u_chk (.*);

`default_nettype wire

FILE: tb/plane_angle_from_normals_test.sv
// ----------------------------------------------------------------------------
// plane_angle_from_normals_test
// Self-checking bench for the plane angle pipeline. A directed table covers
// zero normals, the most negative coordinate, full-scale and parallel,
// antiparallel and perpendicular pairs. Random pairs follow. Each untyped word
// is checked against a bit-exact predictor: exact integer norms, root search
// for cosine and sine, then a 30-step CORDIC. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plane_angle_from_normals_test;

    typedef logic signed [pafn_pkg::COORD_WIDTH-1:0] coord_t;

    typedef struct {
        logic [pafn_pkg::ANGLE_W-1:0] angle;
        logic                         zero;
    } angle_word_t;

    typedef struct {
        coord_t ax, ay, az, bx, by, bz;
        bit     fixed;      // expected result typed in below
        logic [pafn_pkg::ANGLE_W-1:0] angle;
        logic   zero;
    } stim_row_t;

    localparam int RANDOM_PAIRS = 540;
    localparam int DRAIN_CYCLES = 160;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    coord_t first_x = '0, first_y = '0, first_z = '0;
    coord_t second_x = '0, second_y = '0, second_z = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    logic [pafn_pkg::ANGLE_W-1:0] angle_rad;
    logic   zero_normal;

    angle_word_t angle_due[$];
    int  mismatches = 0;
    int  words_in = 0;
    int  words_out = 0;
    int  zero_seen = 0;
    bit  calm = 1'b0;       // no idling on either side
    bit  hold_done = 1'b0;
    int  hold_left = 0;

    stim_row_t rows[$];

    plane_angle_from_normals dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .first_x    (first_x),
        .first_y    (first_y),
        .first_z    (first_z),
        .second_x   (second_x),
        .second_y   (second_y),
        .second_z   (second_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .angle_rad  (angle_rad),
        .zero_normal(zero_normal)
    );

    always #5 clk = ~clk;

    // largest t <= 2^30 with t^2 * den <= num * 2^60
    function automatic longint unsigned q30_root(input bit [191:0] num,
                                                 input bit [191:0] den);
        bit [191:0] rhs;
        bit [191:0] sq;
        longint unsigned t;
        longint unsigned cand;
        rhs = num << (2 * pafn_pkg::QBITS);
        t = 0;
        for (int b = pafn_pkg::QBITS; b >= 0; b--)
        begin
            cand = t | (64'd1 << b);
            if (cand <= (64'd1 << pafn_pkg::QBITS))
            begin
                sq = 192'(cand * cand);
                if (sq * den <= rhs)
                    t = cand;
            end
        end
        return t;
    endfunction

    function automatic angle_word_t plane_angle(input coord_t ax, ay, az, bx, by, bz);
        angle_word_t r;
        longint s1, s2, dp;
        bit [191:0] den, dd;
        longint x, y, z, dx, dy;
        s1 = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
        s2 = longint'(bx) * bx + longint'(by) * by + longint'(bz) * bz;
        dp = longint'(ax) * bx + longint'(ay) * by + longint'(az) * bz;
        if (dp < 0)
            dp = -dp;
        if (s1 == 0 || s2 == 0)
        begin
            r.angle = '0;
            r.zero = 1'b1;
            return r;
        end
        den = 192'(s1) * 192'(s2);
        dd = 192'(dp) * 192'(dp);
        x = longint'(q30_root(dd, den));
        y = longint'(q30_root(den - dd, den));
        z = 0;
        // rotate toward the x axis, accumulating the angle
        for (int i = 0; i < pafn_pkg::CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += longint'(pafn_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= longint'(pafn_pkg::ATAN_TAB[i]);
            end
        end
        if (z < 0)
            z = 0;
        if (z > longint'(pafn_pkg::HALF_PI))
            z = longint'(pafn_pkg::HALF_PI);
        r.angle = pafn_pkg::ANGLE_W'((z + (longint'(1) << (pafn_pkg::RND_SHIFT - 1)))
                                     >>> pafn_pkg::RND_SHIFT);
        r.zero = 1'b0;
        return r;
    endfunction

    function automatic coord_t pick_coord(input int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 6)) - 3;
            2: return ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
            default: return coord_t'($urandom_range(0, 400)) - 200;
        endcase
    endfunction

    function automatic void add_row(input coord_t ax, ay, az, bx, by, bz, input bit fixed,
                                    input logic [pafn_pkg::ANGLE_W-1:0] angle,
                                    input logic zero);
        stim_row_t row;
        row.ax = ax; row.ay = ay; row.az = az;
        row.bx = bx; row.by = by; row.bz = bz;
        row.fixed = fixed; row.angle = angle; row.zero = zero;
        rows.push_back(row);
    endfunction

    // offer one word and hold it until accepted
    task automatic send_pair(input coord_t ax, ay, az, bx, by, bz, input bit fixed,
                             input angle_word_t typed);
        angle_word_t due;
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        first_x <= ax; first_y <= ay; first_z <= az;
        second_x <= bx; second_y <= by; second_z <= bz;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        due = fixed ? typed : plane_angle(ax, ay, az, bx, by, bz);
        angle_due.push_back(due);
        words_in++;
    endtask

    // check each accepted result word
    always @(posedge clk)
    begin
        angle_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                words_out++;
                if (zero_normal)
                    zero_seen++;
                if (angle_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: angle %0d zero %0b",
                                 angle_rad, zero_normal);
                end
                else
                begin
                    want = angle_due.pop_front();
                    if (angle_rad !== want.angle || zero_normal !== want.zero)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: angle exp %0d got %0d, zero exp %0b got %0b",
                                     want.angle, angle_rad, want.zero, zero_normal);
                    end
                end
            end
        end
    end

    // pick the next output stall; hold off once for a long stretch
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (!hold_done && words_out >= 100)
            begin
                hold_done <= 1'b1;
                hold_left <= 400;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < 25);
        end
    end

    initial
    begin
        #3_000_000;
        $display("timeout with %0d result words outstanding", angle_due.size());
        $display("** plane_angle_from_normals: FAILED **");
        $finish;
    end

    initial
    begin
        stim_row_t   row;
        angle_word_t typed;
        int          mode;

        // zero normals give angle 0 and the flag
        add_row(0, 0, 0, 5, -3, 2, 1, '0, 1'b1);
        add_row(16'sh7FFF, 1, -1, 0, 0, 0, 1, '0, 1'b1);
        add_row(0, 0, 0, 0, 0, 0, 1, '0, 1'b1);
        add_row(0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 1, '0, 1'b1);
        // parallel, antiparallel, perpendicular and oblique pairs
        add_row(1, 0, 0, 1, 0, 0, 0, '0, 1'b0);
        add_row(1, 2, 3, -2, -4, -6, 0, '0, 1'b0);
        add_row(1, 0, 0, 0, 1, 0, 0, '0, 1'b0);
        add_row(0, 0, 7, 9, -9, 0, 0, '0, 1'b0);
        add_row(1, 1, 0, 1, 0, 0, 0, '0, 1'b0);
        add_row(1, 1, 1, 1, 0, 0, 0, '0, 1'b0);
        // most negative and most positive coordinates, then mixed and small values
        add_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                0, '0, 1'b0);
        add_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                0, '0, 1'b0);
        add_row(16'sh7FFF, 16'sh8000, 0, 16'sh7FFF, 16'sh7FFF, 0, 0, '0, 1'b0);
        add_row(16'sh7FFF, 0, 0, 1, 16'sh7FFF, 0, 0, '0, 1'b0);
        add_row(16'sh5555, 16'shAAAA, 16'sh0F0F, 16'shF0F0, 16'sh3333, 16'shCCCC,
                0, '0, 1'b0);
        add_row(-1, -1, -1, 1, 1, -1, 0, '0, 1'b0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (rows[i])
        begin
            row = rows[i];
            typed.angle = row.angle;
            typed.zero = row.zero;
            send_pair(row.ax, row.ay, row.az, row.bx, row.by, row.bz, row.fixed, typed);
        end

        // random pairs: half wide values, the rest small, extreme or zero
        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            calm = (n >= 250 && n < 350);
            if (n == 200)
            begin
                // pause until the pipe is empty
                in_valid <= 1'b0;
                while (angle_due.size() != 0)
                    @(posedge clk);
            end
            mode = $urandom_range(0, 9);
            if (mode == 9)
                send_pair(0, 0, 0, pick_coord(0), pick_coord(1), pick_coord(0), 0, typed);
            else if (mode == 8)
                send_pair(pick_coord(2), pick_coord(2), pick_coord(2),
                          pick_coord(2), pick_coord(2), pick_coord(2), 0, typed);
            else
            begin
                mode = (mode < 5) ? 0 : mode - 4;
                send_pair(pick_coord(mode), pick_coord(mode), pick_coord(mode),
                          pick_coord(mode), pick_coord(mode), pick_coord(mode), 0, typed);
            end
        end
        in_valid <= 1'b0;

        while (angle_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d plane pairs sent, %0d angles returned, %0d with a zero normal",
                 words_in, words_out, zero_seen);
        $display("covered extremes, zero normals, a long output hold and an empty-pipe pause");
        if (mismatches == 0 && angle_due.size() == 0)
            $display("** plane_angle_from_normals: PASSED **");
        else
            $display("** plane_angle_from_normals: FAILED **");
        $finish;
    end

endmodule

FILE: plane_angle_from_normals.f
+incdir+rtl/core
rtl/core/pafn_pkg.sv
rtl/core/pafn_front.sv
rtl/core/pafn_divide.sv
rtl/core/pafn_root.sv
rtl/core/pafn_cordic.sv
rtl/core/plane_angle_from_normals.sv
rtl/core/plane_angle_from_normals_chk.sv
tb/plane_angle_from_normals_test.sv
